// ===== hdl/gdrc_pkg.sv =====
`default_nettype none
package gdrc_pkg;

    // default sizes
    localparam int MAP_SIZE_DEF  = 64;
    localparam int SCREEN_W_DEF  = 640;
    localparam int SCREEN_H_DEF  = 480;
    localparam int FRAC_BITS_DEF = 16;

    // item kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 22;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_X   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_X = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_Y = 3'd5;

    // register reset values
    localparam logic [21:0]        POS_X_RST   = 22'd131072;
    localparam logic [21:0]        POS_Y_RST   = 22'd131072;
    localparam logic signed [17:0] DIR_X_RST   = -18'sd65536;
    localparam logic signed [17:0] DIR_Y_RST   = 18'sd0;
    localparam logic signed [17:0] PLANE_X_RST = 18'sd0;
    localparam logic signed [17:0] PLANE_Y_RST = 18'sd43253;

    // stream widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [21:0]        pos_x;
        logic [21:0]        pos_y;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] plane_x;
        logic signed [17:0] plane_y;
    } t_cfg;

    // classified item as queued between front and back
    typedef struct packed {
        logic       op;
        logic       wr_ok;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [7:0] cell_value;
        logic [9:0] column;
    } t_item;

    typedef struct packed {
        logic        hit_found;
        logic        wall_side;
        logic [5:0]  hit_x;
        logic [5:0]  hit_y;
        logic [7:0]  wall_value;
        logic [15:0] line_height;
        logic [8:0]  draw_start;
        logic [8:0]  draw_end;
    } t_res;

endpackage
`default_nettype wire

// ===== hdl/gdrc_ram.sv =====
`default_nettype none
module gdrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/gdrc_div.sv =====
`default_nettype none
module gdrc_div #(
    parameter int DVD_W = 42,
    parameter int DVS_W = 29
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dvd,
    input  wire logic [DVS_W-1:0] i_dvs,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic             r_done;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    // one restoring step per cycle
    assign rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign ge     = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dvd;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

// ===== hdl/gdrc_front.sv =====
`default_nettype none
module gdrc_front #(
    parameter int MAP_SIZE = gdrc_pkg::MAP_SIZE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // cell_x[5:0], cell_y[11:6], cell_value[19:12], column[29:20], zero pad
    input  wire logic [gdrc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // op[0]
    input  wire logic                           s_axis_tuser,
    input  wire logic                           i_enable,
    output gdrc_pkg::t_item                     o_item,
    output logic                                o_item_valid,
    input  wire logic                           i_item_pop
);

    localparam int QD = 2;
    localparam int QP_W = $clog2(QD);

    gdrc_pkg::t_item r_queue [QD];
    logic [QP_W-1:0] r_wptr;
    logic [QP_W-1:0] r_rptr;
    logic [QP_W:0]   r_count;
    gdrc_pkg::t_item item_in;
    logic            push;
    logic            pop;

    // classify the incoming transaction
    always_comb begin
        item_in.op         = s_axis_tuser;
        item_in.cell_x     = s_axis_tdata[5:0];
        item_in.cell_y     = s_axis_tdata[11:6];
        item_in.cell_value = s_axis_tdata[19:12];
        item_in.column     = s_axis_tdata[29:20];
        item_in.wr_ok      = (9'(s_axis_tdata[5:0]) < 9'(MAP_SIZE))
                          && (9'(s_axis_tdata[11:6]) < 9'(MAP_SIZE));
    end

    assign s_axis_tready = i_enable && (r_count != (QP_W+1)'(QD));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_item_valid  = (r_count != '0);
    assign pop           = i_item_pop && o_item_valid;
    assign o_item        = r_queue[r_rptr];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (QP_W+1)'(push) - (QP_W+1)'(pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wptr] <= item_in;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/gdrc_back.sv =====
`default_nettype none
module gdrc_back #(
    parameter int MAP_SIZE  = gdrc_pkg::MAP_SIZE_DEF,
    parameter int SCREEN_W  = gdrc_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H  = gdrc_pkg::SCREEN_H_DEF,
    parameter int FRAC_BITS = gdrc_pkg::FRAC_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  gdrc_pkg::t_cfg       i_cfg,
    input  gdrc_pkg::t_item      i_item,
    input  wire logic            i_item_valid,
    output logic                 o_item_pop,
    output logic                 o_ready,
    output gdrc_pkg::t_res       o_res,
    output logic                 o_res_valid,
    input  wire logic            i_res_ready
);

    localparam int F      = FRAC_BITS;
    localparam int CAM_W  = F + 12;
    localparam int RD_W   = 30;
    localparam int MAG_W  = 29;
    localparam int MX_W   = (((22 - F) > 9) ? (22 - F) : 9) + 2;
    localparam int NUM_W  = (((MX_W + F) > 23) ? (MX_W + F) : 23) + 1;
    localparam int H_W    = $clog2(SCREEN_H + 1);
    localparam int W_W    = $clog2(SCREEN_W + 1);
    localparam int DVD_A  = ((2 * F + 1) > (H_W + MAG_W)) ? (2 * F + 1) : (H_W + MAG_W);
    localparam int DVD_W  = (DVD_A > (F + 11)) ? DVD_A : (F + 11);
    localparam int DVS_A  = (MAG_W > NUM_W) ? MAG_W : NUM_W;
    localparam int DVS_W  = (DVS_A > W_W) ? DVS_A : W_W;
    localparam int DL_W   = 2 * F + 1;
    localparam int SIDE_W = 2 * F + 9;
    localparam int DEPTH  = MAP_SIZE * MAP_SIZE;
    localparam int AW     = $clog2(DEPTH);
    localparam int MI_W   = $clog2(MAP_SIZE);
    localparam int G_LIM  = 2 * MAP_SIZE + 2;
    localparam int G_W    = $clog2(G_LIM + 1);

    localparam logic [F:0]                ONE_F   = (F + 1)'(1) << F;
    localparam logic signed [CAM_W-1:0]   ONE_CAM = CAM_W'(1) << F;
    localparam logic signed [NUM_W-1:0]   ONE_NUM = NUM_W'(1) << F;
    localparam logic signed [MX_W-1:0]    STEP_P  = MX_W'(1);
    localparam logic signed [MX_W-1:0]    STEP_M  = -MX_W'(1);
    localparam logic signed [MX_W-1:0]    MAP_LIM = MX_W'(MAP_SIZE);
    localparam logic signed [17:0]        HALF_H  = 18'(SCREEN_H / 2);
    localparam logic signed [17:0]        LAST_H  = 18'(SCREEN_H - 1);

    // sequencer codes
    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_CAM  = 5'd2;
    localparam logic [4:0] S_RD   = 5'd3;
    localparam logic [4:0] S_DX   = 5'd4;
    localparam logic [4:0] S_WDX  = 5'd5;
    localparam logic [4:0] S_DY   = 5'd6;
    localparam logic [4:0] S_WDY  = 5'd7;
    localparam logic [4:0] S_SX0  = 5'd8;
    localparam logic [4:0] S_SX1  = 5'd9;
    localparam logic [4:0] S_SY0  = 5'd10;
    localparam logic [4:0] S_SY1  = 5'd11;
    localparam logic [4:0] S_WALK = 5'd12;
    localparam logic [4:0] S_LH   = 5'd13;
    localparam logic [4:0] S_WLH  = 5'd14;
    localparam logic [4:0] S_FIN  = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    logic [4:0]               r_state;
    logic [AW-1:0]            r_clr_addr;
    logic signed [CAM_W-1:0]  r_cam;
    logic signed [RD_W-1:0]   r_rdx;
    logic signed [RD_W-1:0]   r_rdy;
    logic [MAG_W-1:0]         r_magx;
    logic [MAG_W-1:0]         r_magy;
    logic                     r_infx;
    logic                     r_infy;
    logic                     r_negx;
    logic                     r_negy;
    logic [DL_W-1:0]          r_dx;
    logic [DL_W-1:0]          r_dy;
    logic [SIDE_W-1:0]        r_sidex;
    logic [SIDE_W-1:0]        r_sidey;
    logic [SIDE_W-1:0]        r_prod;
    logic signed [MX_W-1:0]   r_mx;
    logic signed [MX_W-1:0]   r_my;
    logic                     r_side;
    logic                     r_pend;
    logic [G_W-1:0]           r_guard;
    logic [7:0]               r_val;
    logic                     r_hit;
    logic [15:0]              r_lh;
    logic [8:0]               r_ds;
    logic [8:0]               r_de;
    gdrc_pkg::t_res           r_ores;
    logic                     r_ovalid;

    logic                     div_start;
    logic [DVD_W-1:0]         div_dvd;
    logic [DVS_W-1:0]         div_dvs;
    logic                     div_done;
    logic [DVD_W-1:0]         div_quo;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [7:0]               ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [7:0]               ram_rdata;

    logic signed [17+CAM_W:0] prod_px;
    logic signed [17+CAM_W:0] prod_py;
    logic signed [RD_W-1:0]   neg_rdx;
    logic signed [RD_W-1:0]   neg_rdy;
    logic [MAG_W-1:0]         mag_x;
    logic [MAG_W-1:0]         mag_y;
    logic [F:0]               frac_x;
    logic [F:0]               frac_y;
    logic [F:0]               frac_sel;
    logic [DL_W-1:0]          dl_sel;
    logic [2*F+1:0]           hi_prod;
    logic [2*F:0]             lo_prod;
    logic                     take_x;
    logic signed [MX_W-1:0]   nmx;
    logic signed [MX_W-1:0]   nmy;
    logic                     off_map;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-1:0]         mag_num;
    logic [MAG_W-1:0]         q_sel;
    logic [DVD_W-1:0]         lh_dvd;
    logic [14:0]              half_lh;
    logic signed [17:0]       ds_s;
    logic signed [17:0]       de_s;
    logic                     out_free;

    gdrc_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    gdrc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ray components and their magnitudes
    assign prod_px = i_cfg.plane_x * r_cam;
    assign prod_py = i_cfg.plane_y * r_cam;
    assign neg_rdx = -r_rdx;
    assign neg_rdy = -r_rdy;
    assign mag_x   = r_rdx[RD_W-1] ? neg_rdx[MAG_W-1:0] : r_rdx[MAG_W-1:0];
    assign mag_y   = r_rdy[RD_W-1] ? neg_rdy[MAG_W-1:0] : r_rdy[MAG_W-1:0];

    // distance to the first boundary and its scaled side distance
    assign frac_x   = r_negx ? {1'b0, i_cfg.pos_x[F-1:0]} : ONE_F - {1'b0, i_cfg.pos_x[F-1:0]};
    assign frac_y   = r_negy ? {1'b0, i_cfg.pos_y[F-1:0]} : ONE_F - {1'b0, i_cfg.pos_y[F-1:0]};
    assign frac_sel = (r_state == S_SX0 || r_state == S_SX1) ? frac_x : frac_y;
    assign dl_sel   = (r_state == S_SX0 || r_state == S_SX1) ? r_dx : r_dy;
    assign hi_prod  = frac_sel * dl_sel[DL_W-1:F];
    assign lo_prod  = frac_sel * dl_sel[F-1:0];

    // one grid step
    assign take_x  = !r_infx && (r_infy || (r_sidex < r_sidey));
    assign nmx     = take_x ? (r_mx + (r_negx ? STEP_M : STEP_P)) : r_mx;
    assign nmy     = take_x ? r_my : (r_my + (r_negy ? STEP_M : STEP_P));
    assign off_map = (nmx < 0) || (nmx >= MAP_LIM) || (nmy < 0) || (nmy >= MAP_LIM);
    assign ram_raddr = AW'(nmx[MI_W-1:0]) * AW'(MAP_SIZE) + AW'(nmy[MI_W-1:0]);

    // perpendicular distance numerator on the crossed axis
    always_comb begin
        if (r_side) begin
            num = (NUM_W'(r_my) <<< F)
                - $signed({{(NUM_W-22){1'b0}}, i_cfg.pos_y})
                + (r_negy ? ONE_NUM : '0);
            q_sel = r_magy;
        end else begin
            num = (NUM_W'(r_mx) <<< F)
                - $signed({{(NUM_W-22){1'b0}}, i_cfg.pos_x})
                + (r_negx ? ONE_NUM : '0);
            q_sel = r_magx;
        end
        mag_num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    end
    assign lh_dvd = DVD_W'(SCREEN_H) * DVD_W'(q_sel);

    // clamped row range
    assign half_lh = r_lh[15:1];
    assign ds_s    = HALF_H - $signed({3'b000, half_lh});
    assign de_s    = HALF_H + $signed({3'b000, half_lh});

    // divider requests
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        unique case (r_state)
            S_IDLE: begin
                div_start = i_item_valid && (i_item.op == gdrc_pkg::OP_CAST);
                div_dvd   = DVD_W'(i_item.column) << (F + 1);
                div_dvs   = DVS_W'(SCREEN_W);
            end
            S_DX: begin
                div_start = (mag_x != '0);
                div_dvd   = DVD_W'(1) << (2 * F);
                div_dvs   = DVS_W'(mag_x);
            end
            S_DY: begin
                div_start = (mag_y != '0);
                div_dvd   = DVD_W'(1) << (2 * F);
                div_dvs   = DVS_W'(mag_y);
            end
            S_LH: begin
                div_start = (q_sel != '0) && (num != '0);
                div_dvd   = lh_dvd;
                div_dvs   = DVS_W'(mag_num);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // map writes: clearing sweep or a write item
    always_comb begin
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_IDLE) && i_item_valid
                     && (i_item.op == gdrc_pkg::OP_WRITE) && i_item.wr_ok;
            ram_waddr = AW'(i_item.cell_x) * AW'(MAP_SIZE) + AW'(i_item.cell_y);
            ram_wdata = i_item.cell_value;
        end
    end

    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;
    assign o_ready    = (r_state != S_CLR);
    assign out_free   = !r_ovalid || i_res_ready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (div_start) begin
                        r_state <= S_CAM;
                    end
                end
                S_CAM: begin
                    if (div_done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD:  r_state <= S_DX;
                S_DX:  r_state <= div_start ? S_WDX : S_DY;
                S_WDX: begin
                    if (div_done) begin
                        r_state <= S_DY;
                    end
                end
                S_DY:  r_state <= div_start ? S_WDY : S_SX0;
                S_WDY: begin
                    if (div_done) begin
                        r_state <= S_SX0;
                    end
                end
                S_SX0: r_state <= S_SX1;
                S_SX1: r_state <= S_SY0;
                S_SY0: r_state <= S_SY1;
                S_SY1: r_state <= S_WALK;
                S_WALK: begin
                    if (r_pend && ram_rdata != '0) begin
                        r_state <= S_LH;
                    end else if (r_guard == G_W'(G_LIM) || off_map) begin
                        r_state <= S_OUT;
                    end
                end
                S_LH:  r_state <= div_start ? S_WLH : S_FIN;
                S_WLH: begin
                    if (div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ray datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CAM: begin
                r_cam <= CAM_W'(div_quo) - ONE_CAM;
            end
            S_RD: begin
                r_rdx <= RD_W'(i_cfg.dir_x) + RD_W'(prod_px >>> F);
                r_rdy <= RD_W'(i_cfg.dir_y) + RD_W'(prod_py >>> F);
                r_mx  <= MX_W'(i_cfg.pos_x >> F);
                r_my  <= MX_W'(i_cfg.pos_y >> F);
            end
            S_DX: begin
                r_magx <= mag_x;
                r_infx <= (mag_x == '0);
                r_negx <= r_rdx[RD_W-1];
                r_dx   <= '0;
            end
            S_WDX: begin
                if (div_done) begin
                    r_dx <= DL_W'(div_quo);
                end
            end
            S_DY: begin
                r_magy <= mag_y;
                r_infy <= (mag_y == '0);
                r_negy <= r_rdy[RD_W-1];
                r_dy   <= '0;
            end
            S_WDY: begin
                if (div_done) begin
                    r_dy <= DL_W'(div_quo);
                end
            end
            S_SX0, S_SY0: begin
                r_prod <= SIDE_W'(hi_prod);
            end
            S_SX1: begin
                r_sidex <= r_prod + SIDE_W'(lo_prod >> F);
            end
            S_SY1: begin
                r_sidey <= r_prod + SIDE_W'(lo_prod >> F);
                r_pend  <= 1'b0;
                r_guard <= '0;
                r_hit   <= 1'b0;
            end
            S_WALK: begin
                if (r_pend && ram_rdata != '0) begin
                    r_val <= ram_rdata;
                    r_hit <= 1'b1;
                end else if (r_guard != G_W'(G_LIM)) begin
                    if (take_x) begin
                        r_sidex <= r_sidex + SIDE_W'(r_dx);
                        r_side  <= 1'b0;
                    end else begin
                        if (!r_infy) begin
                            r_sidey <= r_sidey + SIDE_W'(r_dy);
                        end
                        r_side <= 1'b1;
                    end
                    r_mx    <= nmx;
                    r_my    <= nmy;
                    r_pend  <= 1'b1;
                    r_guard <= r_guard + 1'b1;
                end
            end
            S_LH: begin
                if (q_sel == '0) begin
                    r_lh <= '0;
                end else if (num == '0) begin
                    r_lh <= 16'hFFFF;
                end
            end
            S_WLH: begin
                if (div_done) begin
                    r_lh <= (div_quo > DVD_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
                end
            end
            S_FIN: begin
                r_ds <= (ds_s < 0) ? 9'd0 : ds_s[8:0];
                r_de <= (de_s > LAST_H) ? LAST_H[8:0] : de_s[8:0];
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            if (r_hit) begin
                r_ores.hit_found   <= 1'b1;
                r_ores.wall_side   <= r_side;
                r_ores.hit_x       <= r_mx[5:0];
                r_ores.hit_y       <= r_my[5:0];
                r_ores.wall_value  <= r_val;
                r_ores.line_height <= r_lh;
                r_ores.draw_start  <= r_ds;
                r_ores.draw_end    <= r_de;
            end else begin
                r_ores <= '0;
            end
        end
    end

    assign o_res       = r_ores;
    assign o_res_valid = r_ovalid;

endmodule
`default_nettype wire

// ===== hdl/grid_dda_raycast_column_unit.sv =====
`default_nettype none
// Column raycaster over a square grid map held in on-chip memory.
// Input stream: tuser carries the item kind (write cell or cast column),
// tdata the cell coordinates, cell value and screen column. A write item
// stores one map cell and returns nothing; a cast item returns exactly one
// result on the output stream (hit flag in tuser, hit cell, wall side,
// wall value, slice height and clamped first/last rows in tdata).
// Configuration registers (viewer position, direction, camera plane) are
// written through the plain write port; the user must write them only
// while the unit is idle, as the unit itself does not enforce this.
// A write stores its map cell in the back end. A cast uses the shared
// bit-serial divider for the column scale and the two reciprocal distances,
// walks up to 2 * MAP_SIZE + 2 grid steps with one map read each, then
// divides for the slice height (DVD_W is 38 at default sizes).
// One item is worked on at a time; a two-entry queue in front keeps taking
// items while the back end works or waits on the output register.
// Reset: synchronous, active low; after reset the map is swept to zero,
// all MAP_SIZE * MAP_SIZE cells (4096 at default); meanwhile s_axis_tready
// stays low. A stalled receiver holds the result in the output register and
// the back end waits before loading the next one.
module grid_dda_raycast_column_unit #(
    parameter int MAP_SIZE  = gdrc_pkg::MAP_SIZE_DEF,
    parameter int SCREEN_W  = gdrc_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H  = gdrc_pkg::SCREEN_H_DEF,
    parameter int FRAC_BITS = gdrc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // cell_x[5:0], cell_y[11:6], cell_value[19:12], column[29:20], zero pad
    input  wire logic [gdrc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op[0]
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // wall_side[0], hit_x[6:1], hit_y[12:7], wall_value[20:13],
    // line_height[36:21], draw_start[45:37], draw_end[54:46], zero pad
    output logic      [gdrc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // hit_found[0]
    output logic                                  m_axis_tuser,
    input  wire logic                             i_cfg_we,
    input  wire logic [gdrc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [gdrc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    gdrc_pkg::t_cfg  r_cfg;
    gdrc_pkg::t_item item;
    logic            item_valid;
    logic            item_pop;
    logic            back_ready;
    gdrc_pkg::t_res  res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x   <= gdrc_pkg::POS_X_RST;
            r_cfg.pos_y   <= gdrc_pkg::POS_Y_RST;
            r_cfg.dir_x   <= gdrc_pkg::DIR_X_RST;
            r_cfg.dir_y   <= gdrc_pkg::DIR_Y_RST;
            r_cfg.plane_x <= gdrc_pkg::PLANE_X_RST;
            r_cfg.plane_y <= gdrc_pkg::PLANE_Y_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                gdrc_pkg::REG_POS_X:   r_cfg.pos_x   <= i_cfg_wdata;
                gdrc_pkg::REG_POS_Y:   r_cfg.pos_y   <= i_cfg_wdata;
                gdrc_pkg::REG_DIR_X:   r_cfg.dir_x   <= i_cfg_wdata[17:0];
                gdrc_pkg::REG_DIR_Y:   r_cfg.dir_y   <= i_cfg_wdata[17:0];
                gdrc_pkg::REG_PLANE_X: r_cfg.plane_x <= i_cfg_wdata[17:0];
                gdrc_pkg::REG_PLANE_Y: r_cfg.plane_y <= i_cfg_wdata[17:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    gdrc_front #(
        .MAP_SIZE (MAP_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_enable      (back_ready),
        .o_item        (item),
        .o_item_valid  (item_valid),
        .i_item_pop    (item_pop)
    );

    gdrc_back #(
        .MAP_SIZE  (MAP_SIZE),
        .SCREEN_W  (SCREEN_W),
        .SCREEN_H  (SCREEN_H),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .o_ready      (back_ready),
        .o_res        (res),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready)
    );

    // result packing
    assign m_axis_tuser = res.hit_found;
    assign m_axis_tdata = {1'b0, res.draw_end, res.draw_start, res.line_height,
                           res.wall_value, res.hit_y, res.hit_x, res.wall_side};

endmodule
`default_nettype wire

// ===== tb/grid_dda_raycast_column_unit_tb.sv =====
module grid_dda_raycast_column_unit_tb;
    import gdrc_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     HOLD_CYCLES = 2000;
    localparam int     SETTLE      = 400;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    grid_dda_raycast_column_unit u_top (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_addr, .i_cfg_wdata
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the map and the view registers
    logic [7:0] grid_mem [0:4095];
    longint     view_pos_x, view_pos_y, view_dir_x, view_dir_y, view_pl_x, view_pl_y;

    t_res   pending_hits [$];
    int     n_err, n_cast, n_hit, n_write, n_got;
    longint cycles;
    bit     hold_req;

    // cycle counter with timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[grid_dda_raycast_column_unit] ERROR");
            $finish;
        end
    end

    function automatic longint sx18(logic [17:0] v);
        return longint'($signed(v));
    endfunction

    // expected result of one ray cast against the shadow map
    function automatic t_res trace_column(logic [9:0] col);
        longint cam, rdx, rdy, mx, my, stx, sty, num, lh, ds, de;
        longint unsigned dxm, dym, dlx, dly, sdx, sdy, q;
        bit infx, infy, hit, side;
        logic [7:0] v;
        t_res r;
        r = '0; hit = 0; side = 0; v = '0; dlx = 0; dly = 0; sdx = 0; sdy = 0;
        cam = ((longint'(col) * 2) << 16) / 640 - 65536;
        rdx = view_dir_x + ((view_pl_x * cam) >>> 16);
        rdy = view_dir_y + ((view_pl_y * cam) >>> 16);
        mx = view_pos_x >> 16;
        my = view_pos_y >> 16;
        dxm = rdx < 0 ? -rdx : rdx;
        dym = rdy < 0 ? -rdy : rdy;
        infx = (dxm == 0);
        infy = (dym == 0);
        if (!infx) dlx = (64'd1 << 32) / dxm;
        if (!infy) dly = (64'd1 << 32) / dym;
        stx = rdx < 0 ? -1 : 1;
        sty = rdy < 0 ? -1 : 1;
        if (!infx)
            sdx = ((rdx < 0 ? view_pos_x - (mx << 16) : ((mx + 1) << 16) - view_pos_x)
                   * dlx) >> 16;
        if (!infy)
            sdy = ((rdy < 0 ? view_pos_y - (my << 16) : ((my + 1) << 16) - view_pos_y)
                   * dly) >> 16;
        // grid walk, start cell never tested
        for (int g = 0; g < 130; g++) begin
            if (!infx && (infy || sdx < sdy)) begin
                sdx += dlx; mx += stx; side = 0;
            end else begin
                if (!infy) sdy += dly;
                my += sty; side = 1;
            end
            if (mx < 0 || mx > 63 || my < 0 || my > 63) break;
            v = grid_mem[mx * 64 + my];
            if (v != 0) begin
                hit = 1;
                break;
            end
        end
        if (!hit) return r;
        if (side == 0) begin
            num = (mx << 16) - view_pos_x + (stx < 0 ? 65536 : 0);
            q = dxm;
        end else begin
            num = (my << 16) - view_pos_y + (sty < 0 ? 65536 : 0);
            q = dym;
        end
        if (q == 0) lh = 0;
        else if (num == 0) lh = 65535;
        else begin
            lh = (480 * q) / (num < 0 ? -num : num);
            if (lh > 65535) lh = 65535;
        end
        ds = 240 - lh / 2;
        if (ds < 0) ds = 0;
        de = lh / 2 + 240;
        if (de > 479) de = 479;
        r.hit_found = 1'b1; r.wall_side = side;
        r.hit_x = mx[5:0]; r.hit_y = my[5:0]; r.wall_value = v;
        r.line_height = lh[15:0]; r.draw_start = ds[8:0]; r.draw_end = de[8:0];
        return r;
    endfunction

    task automatic report_err(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        n_err++;
    endtask

    // output side: compare each transaction with the oldest expected result record
    always @(posedge i_clk) begin
        t_res want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit_found   = m_axis_tuser;
            got.wall_side   = m_axis_tdata[0];
            got.hit_x       = m_axis_tdata[6:1];
            got.hit_y       = m_axis_tdata[12:7];
            got.wall_value  = m_axis_tdata[20:13];
            got.line_height = m_axis_tdata[36:21];
            got.draw_start  = m_axis_tdata[45:37];
            got.draw_end    = m_axis_tdata[54:46];
            n_got++;
            if (pending_hits.size() == 0) begin
                report_err("unexpected result", n_got, 0);
            end else begin
                want = pending_hits.pop_front();
                if (got.hit_found != want.hit_found)
                    report_err("hit_found", got.hit_found, want.hit_found);
                if (got.wall_side != want.wall_side)
                    report_err("wall_side", got.wall_side, want.wall_side);
                if (got.hit_x != want.hit_x) report_err("hit_x", got.hit_x, want.hit_x);
                if (got.hit_y != want.hit_y) report_err("hit_y", got.hit_y, want.hit_y);
                if (got.wall_value != want.wall_value)
                    report_err("wall_value", got.wall_value, want.wall_value);
                if (got.line_height != want.line_height)
                    report_err("line_height", got.line_height, want.line_height);
                if (got.draw_start != want.draw_start)
                    report_err("draw_start", got.draw_start, want.draw_start);
                if (got.draw_end != want.draw_end)
                    report_err("draw_end", got.draw_end, want.draw_end);
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    // receiver: random ready with one long hold-off on request
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // offer one item and hold it until the input transaction completes
    task automatic send_item(logic op, logic [5:0] cx, logic [5:0] cy, logic [7:0] val,
                             logic [9:0] col, bit typed, t_res typed_res);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, col, val, cy, cx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_WRITE) begin
            grid_mem[cx * 64 + cy] = val;
            n_write++;
        end else begin
            pending_hits.push_back(typed ? typed_res : trace_column(col));
            n_cast++;
        end
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_POS_X:   view_pos_x = val;
            REG_POS_Y:   view_pos_y = val;
            REG_DIR_X:   view_dir_x = sx18(val[17:0]);
            REG_DIR_Y:   view_dir_y = sx18(val[17:0]);
            REG_PLANE_X: view_pl_x  = sx18(val[17:0]);
            REG_PLANE_Y: view_pl_y  = sx18(val[17:0]);
            default: ;
        endcase
    endtask

    function automatic logic [17:0] rnd18();
        return 18'($urandom_range(0, 262143));
    endfunction

    typedef struct {
        logic       op;
        logic [5:0] cx, cy;
        logic [7:0] val;
        logic [9:0] col;
        bit         typed;
    } t_row;

    // directed items on the reset view, typed rows are no-hit casts
    t_row dir_rows [] = '{
        '{OP_CAST,  0, 0, 0, 0,    1},
        '{OP_CAST,  0, 0, 0, 639,  1},
        '{OP_WRITE, 1, 2, 5, 0,    0},
        '{OP_CAST,  0, 0, 0, 320,  0},
        '{OP_WRITE, 63, 63, 255, 0, 0},
        '{OP_WRITE, 0, 0, 1, 0,    0},
        '{OP_WRITE, 63, 0, 128, 0, 0},
        '{OP_WRITE, 0, 63, 127, 0, 0},
        '{OP_CAST,  0, 0, 0, 0,    0},
        '{OP_CAST,  0, 0, 0, 639,  0},
        '{OP_CAST,  0, 0, 0, 1023, 0},
        '{OP_CAST,  0, 0, 0, 512,  0},
        '{OP_WRITE, 1, 2, 0, 0,    0},
        '{OP_CAST,  0, 0, 0, 320,  0},
        '{OP_WRITE, 0, 2, 170, 0,  0},
        '{OP_CAST,  0, 0, 0, 320,  0},
        '{OP_CAST,  0, 0, 0, 100,  0},
        '{OP_WRITE, 0, 1, 3, 0,    0},
        '{OP_WRITE, 0, 3, 4, 0,    0},
        '{OP_CAST,  0, 0, 0, 1,    0},
        '{OP_CAST,  0, 0, 0, 638,  0}
    };

    initial begin
        logic [21:0] px, py;
        logic [17:0] dx, dy, plx, ply;
        int cxc, cyc, r;
        logic [5:0] wx, wy;
        for (int i = 0; i < 4096; i++) grid_mem[i] = '0;
        view_pos_x = POS_X_RST; view_pos_y = POS_Y_RST;
        view_dir_x = DIR_X_RST; view_dir_y = DIR_Y_RST;
        view_pl_x = PLANE_X_RST; view_pl_y = PLANE_Y_RST;
        n_err = 0; n_cast = 0; n_hit = 0; n_write = 0; n_got = 0;
        cycles = 0; hold_req = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].val,
                      dir_rows[i].col, dir_rows[i].typed, '0);
        s_axis_tvalid <= 1'b0;

        // random phases, each under its own view registers
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case (p)
                1: begin
                    px = 22'h3FFFFF; py = 0; dx = 18'h20000; dy = 18'h1FFFF;
                    plx = 18'h1FFFF; ply = 18'h20000;
                end
                2: begin
                    px = 22'd200000; py = 22'd300000; dx = 0; dy = 0; plx = 0; ply = 0;
                end
                3: begin
                    px = 22'h3FFFFF; py = 22'h3FFFFF; dx = 18'h1FFFF; dy = 0;
                    plx = 0; ply = 18'h1FFFF;
                end
                default: begin
                    px = 22'($urandom_range(65536, 4128767));
                    py = 22'($urandom_range(65536, 4128767));
                    if (p == 0) px = 22'($urandom_range(0, 4194303));
                    dx = rnd18(); dy = rnd18(); plx = rnd18(); ply = rnd18();
                    if (p == 6) begin
                        px[15:0] = 0; py[15:0] = 0;
                    end
                end
            endcase
            set_reg(REG_POS_X, px);
            set_reg(REG_POS_Y, py);
            set_reg(REG_DIR_X, {4'b0, dx});
            set_reg(REG_DIR_Y, {4'b0, dy});
            set_reg(REG_PLANE_X, {4'b0, plx});
            set_reg(REG_PLANE_Y, {4'b0, ply});
            if (p == 4) hold_req = 1;
            cxc = int'(view_pos_x >> 16);
            cyc = int'(view_pos_y >> 16);
            for (int k = 0; k < 230; k++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    // walls mostly clustered around the viewer
                    if ($urandom_range(0, 3) != 0) begin
                        wx = 6'(cxc + $urandom_range(0, 16) - 8);
                        wy = 6'(cyc + $urandom_range(0, 16) - 8);
                    end else begin
                        wx = 6'($urandom_range(0, 63));
                        wy = 6'($urandom_range(0, 63));
                    end
                    send_item(OP_WRITE, wx, wy,
                              ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                              10'($urandom), 0, '0);
                end else begin
                    send_item(OP_CAST, 6'($urandom), 6'($urandom), 8'($urandom),
                              ($urandom_range(0, 9) == 0) ? 10'($urandom_range(640, 1023))
                                                          : 10'($urandom_range(0, 639)),
                              0, '0);
                end
            end
            s_axis_tvalid <= 1'b0;
        end

        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d cell writes and %0d ray casts over 8 view settings,",
                 n_write, n_cast);
        $display("%0d results checked with one long output stall", n_got);
        if (n_err == 0) begin
            $display("[grid_dda_raycast_column_unit] OK");
        end else begin
            $display("[grid_dda_raycast_column_unit] ERROR");
        end
        $finish;
    end

endmodule
